FILE: rtl/core/cul_pkg.sv
`timescale 1ns / 1ps

package cul_pkg;

   // Limits of the configuration.
   localparam int MAX_SET  = 64;
   localparam int MAX_PICK = 16;

   // Field widths.
   localparam int SET_W   = 7;
   localparam int PICK_W  = 5;
   localparam int COUNT_W = 49;

   // Result buffer: one entry per element of a combination.
   localparam int POS_W = $clog2(MAX_PICK + 1);
   localparam int IDX_W = $clog2(MAX_PICK);

   // The divider takes count*picks_left, a few quotient bits per cycle.
   localparam int PROD_W   = COUNT_W + PICK_W;
   localparam int DIV_STEP = 4;
   localparam int DIV_ITER = (PROD_W + DIV_STEP - 1) / DIV_STEP;
   localparam int DIV_W    = DIV_ITER * DIV_STEP;
   localparam int ITER_W   = $clog2(DIV_ITER);

   // Configuration port.
   localparam int ADDR_W = 5;
   localparam int DATA_W = 64;
   localparam logic [ADDR_W-1:0] REG_SET_SIZE    = 5'd0;
   localparam logic [ADDR_W-1:0] REG_SUBSET_SIZE = 5'd8;
   localparam logic [ADDR_W-1:0] REG_TOTAL_COUNT = 5'd16;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST,
      ST_DIV,
      ST_DECIDE,
      ST_EMIT,
      ST_ERROR
   } state_type;

endpackage

FILE: rtl/core/combination_unrank_lex.sv
`timescale 1ns / 1ps

// Lexicographic combination unranking. A rank beat is taken when start is
// high and busy is low; busy then stays high until every result of that rank
// has been sent. The block walks the candidates 1..n once, and for each
// candidate it examines it computes count*j/i on one shared divider that
// yields four quotient bits a cycle; the final element needs no divide.
// Results then follow one per cycle on rsp_strobe, ascending, the final one
// with rsp_last; the receiver cannot stall, so each result is present for
// exactly one cycle and must be taken then. A bad request (rank of zero or
// above total_count, n or k of zero, k above n or 16, n above 64, or a walk
// that an inconsistent total_count sends astray) gives a single result with
// rsp_error and rsp_last set and element zero. total_count is not checked
// against n and k. Configuration may be written only while busy is low.
module combination_unrank_lex
   import cul_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               start,
   output logic               busy,
   input  logic [COUNT_W-1:0] req_rank,

   output logic               rsp_strobe,
   output logic [SET_W-1:0]   rsp_element,
   output logic               rsp_last,
   output logic               rsp_error,

   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]  prdata,
   output logic               pready
);

   state_type state_ff, state_in;

   logic [SET_W-1:0]   set_size_ff, set_size_in;
   logic [PICK_W-1:0]  subset_size_ff, subset_size_in;
   logic [COUNT_W-1:0] total_count_ff, total_count_in;

   logic [COUNT_W-1:0] xr_ff, xr_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [SET_W-1:0]   items_ff, items_in;
   logic [PICK_W-1:0]  picks_ff, picks_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]   emit_ff, emit_in;

   logic [SET_W-1:0]   picked_ff [MAX_PICK];
   logic               pick_we;
   logic [SET_W-1:0]   pick_val;

   logic               div_start;
   logic [DIV_W-1:0]   div_dividend;
   logic               div_done;
   logic [DIV_W-1:0]   div_quotient;

   logic               cfg_write;
   logic               req_bad;
   logic [PROD_W-1:0]  product;
   logic [COUNT_W-1:0] ch;
   logic [COUNT_W:0]   rank_diff;
   logic [COUNT_W:0]   last_sum;
   logic [SET_W-1:0]   next_elem;

   // Configuration port: always ready, written on the access cycle.
   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;

   always_comb begin
      set_size_in    = set_size_ff;
      subset_size_in = subset_size_ff;
      total_count_in = total_count_ff;
      if (cfg_write) begin
         case (paddr)
            REG_SET_SIZE:    set_size_in    = pwdata[SET_W-1:0];
            REG_SUBSET_SIZE: subset_size_in = pwdata[PICK_W-1:0];
            REG_TOTAL_COUNT: total_count_in = pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr)
         REG_SET_SIZE:    prdata = DATA_W'(set_size_ff);
         REG_SUBSET_SIZE: prdata = DATA_W'(subset_size_ff);
         REG_TOTAL_COUNT: prdata = DATA_W'(total_count_ff);
         default:         prdata = '0;
      endcase
   end

   // Checks made on the rank beat itself.
   assign req_bad = (set_size_ff == '0) || (set_size_ff > SET_W'(MAX_SET)) ||
                    (subset_size_ff == '0) ||
                    (SET_W'(subset_size_ff) > set_size_ff) ||
                    (subset_size_ff > PICK_W'(MAX_PICK)) ||
                    (req_rank == '0) || (req_rank > total_count_ff);

   // Data path terms shared by the sequencer.
   assign product      = PROD_W'(cnt_ff) * PROD_W'(picks_ff);
   assign div_dividend = DIV_W'(product);
   assign ch           = div_quotient[COUNT_W-1:0];
   assign rank_diff    = {1'b0, xr_ff} - {1'b0, ch};
   assign next_elem    = set_size_ff - items_ff + 1'b1;
   assign last_sum     = (COUNT_W + 1)'(set_size_ff - items_ff) + {1'b0, xr_ff};

   // Sequencer: skip or pick one candidate per divide, then play out.
   always_comb begin
      state_in  = state_ff;
      xr_in     = xr_ff;
      cnt_in    = cnt_ff;
      items_in  = items_ff;
      picks_in  = picks_ff;
      pos_in    = pos_ff;
      emit_in   = emit_ff;
      pick_we   = 1'b0;
      pick_val  = next_elem;
      div_start = 1'b0;

      rsp_strobe  = 1'b0;
      rsp_element = '0;
      rsp_last    = 1'b0;
      rsp_error   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               xr_in    = req_rank;
               cnt_in   = total_count_ff;
               items_in = set_size_ff;
               picks_in = subset_size_ff;
               pos_in   = '0;
               state_in = req_bad ? ST_ERROR : ST_TEST;
            end
         end

         ST_TEST: begin
            if (picks_ff > PICK_W'(1)) begin
               if (items_ff < SET_W'(picks_ff)) begin
                  state_in = ST_ERROR;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end else begin
               // Final element comes straight from the remaining rank.
               if ((last_sum == '0) || (last_sum > (COUNT_W + 1)'(set_size_ff))) begin
                  state_in = ST_ERROR;
               end else begin
                  pick_we  = 1'b1;
                  pick_val = last_sum[SET_W-1:0];
                  pos_in   = pos_ff + 1'b1;
                  emit_in  = '0;
                  state_in = ST_EMIT;
               end
            end
         end

         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            items_in = items_ff - 1'b1;
            if (rank_diff[COUNT_W] || (rank_diff == '0)) begin
               // Rank falls among combinations starting here: take it.
               pick_we  = 1'b1;
               pos_in   = pos_ff + 1'b1;
               cnt_in   = ch;
               picks_in = picks_ff - 1'b1;
            end else begin
               xr_in  = rank_diff[COUNT_W-1:0];
               cnt_in = cnt_ff - ch;
            end
            state_in = ST_TEST;
         end

         ST_EMIT: begin
            rsp_strobe  = 1'b1;
            rsp_element = picked_ff[emit_ff];
            rsp_last    = (POS_W'(emit_ff) + 1'b1) == pos_ff;
            if (rsp_last) begin
               state_in = ST_IDLE;
            end else begin
               emit_in = emit_ff + 1'b1;
            end
         end

         ST_ERROR: begin
            rsp_strobe = 1'b1;
            rsp_last   = 1'b1;
            rsp_error  = 1'b1;
            state_in   = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         set_size_ff    <= SET_W'(1);
         subset_size_ff <= PICK_W'(1);
         total_count_ff <= COUNT_W'(1);
         xr_ff          <= '0;
         cnt_ff         <= '0;
         items_ff       <= '0;
         picks_ff       <= '0;
         pos_ff         <= '0;
         emit_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         set_size_ff    <= set_size_in;
         subset_size_ff <= subset_size_in;
         total_count_ff <= total_count_in;
         xr_ff          <= xr_in;
         cnt_ff         <= cnt_in;
         items_ff       <= items_in;
         picks_ff       <= picks_in;
         pos_ff         <= pos_in;
         emit_ff        <= emit_in;
      end
   end

   // Chosen elements wait here until the whole walk has succeeded.
   always_ff @(posedge clock) begin
      if (pick_we) begin
         picked_ff[pos_ff[IDX_W-1:0]] <= pick_val;
      end
   end

   cul_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (items_ff),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

endmodule

FILE: rtl/core/cul_divider.sv
`timescale 1ns / 1ps

module cul_divider
   import cul_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              div_start,
   input  logic [DIV_W-1:0]  div_dividend,
   input  logic [SET_W-1:0]  div_divisor,
   output logic              div_done,
   output logic [DIV_W-1:0]  div_quotient
);

   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [SET_W-1:0]  rem_ff, rem_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;

   // Restoring division: the dividend shifts out at the top while quotient
   // bits shift in at the bottom, several bits per cycle.
   always_comb begin
      logic [SET_W:0]   rem_v;
      logic [SET_W-1:0] rem_w;
      logic [DIV_W-1:0] quo_v;
      rem_w   = rem_ff;
      quo_v   = quo_ff;
      for (int b = 0; b < DIV_STEP; b++) begin
         rem_v = {rem_w, quo_v[DIV_W-1]};
         quo_v = {quo_v[DIV_W-2:0], 1'b0};
         if (rem_v >= {1'b0, div_divisor}) begin
            rem_w    = SET_W'(rem_v - {1'b0, div_divisor});
            quo_v[0] = 1'b1;
         end else begin
            rem_w = rem_v[SET_W-1:0];
         end
      end

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      iter_in = iter_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (div_start) begin
         quo_in  = div_dividend;
         rem_in  = '0;
         iter_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         quo_in  = quo_v;
         rem_in  = rem_w;
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ITER_W'(DIV_ITER - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control resets; the data path does not need to.
   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         iter_ff <= iter_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign div_done     = done_ff;
   assign div_quotient = quo_ff;

endmodule

FILE: tb/sv/combination_unrank_lex_test.sv
`timescale 1ns / 1ps

module combination_unrank_lex_test
   import cul_pkg::*;
();

   localparam int CYCLE_LIMIT = 2000000;
   localparam logic [63:0] COUNT_MASK = (64'd1 << COUNT_W) - 64'd1;

   typedef struct packed {
      logic [SET_W-1:0] element;
      logic             last;
      logic             error;
   } element_beat_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [COUNT_W-1:0] req_rank = '0;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [ADDR_W-1:0]  paddr = '0;
   logic [DATA_W-1:0]  pwdata = '0;
   logic               busy;
   logic               rsp_strobe;
   logic [SET_W-1:0]   rsp_element;
   logic               rsp_last;
   logic               rsp_error;
   logic [DATA_W-1:0]  prdata;
   logic               pready;

   // Local copy of the configuration, at its reset values.
   logic [SET_W-1:0]   cfg_set_size = 1;
   logic [PICK_W-1:0]  cfg_subset_size = 1;
   logic [COUNT_W-1:0] cfg_total = 1;

   element_beat_type expected_beats[$];
   int            mismatch_count = 0;
   int            beats_checked = 0;
   int            ranks_sent = 0;
   int            error_ranks = 0;
   int            settings_used = 0;
   longint        cycle_count = 0;
   bit            idle_enable = 1'b1;

   combination_unrank_lex dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_rank    (req_rank),
      .rsp_strobe  (rsp_strobe),
      .rsp_element (rsp_element),
      .rsp_last    (rsp_last),
      .rsp_error   (rsp_error),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #6 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d beats outstanding.",
                  cycle_count, expected_beats.size());
         $display("combination_unrank_lex_test failed");
         $finish;
      end
   end

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("MISMATCH: %s", msg);
   endfunction

   // Binomial coefficient; every intermediate value is itself a coefficient.
   function automatic longint unsigned choose(input int n, input int k);
      longint unsigned c;
      c = 1;
      for (int i = 0; i < k; i++)
         c = c * (n - i) / (i + 1);
      return c;
   endfunction

   // Walk the candidates the way the block does and queue the element beats
   // of the combination at this rank, or a single error beat.
   function automatic void predict_subset(input logic [COUNT_W-1:0] rank);
      longint unsigned  n, k, left, count, share, items, picks, final_el;
      logic [SET_W-1:0] chosen [MAX_PICK];
      int               pos;
      bit               bad;
      element_beat_type beat;
      n = 64'(cfg_set_size);
      k = 64'(cfg_subset_size);
      left = 64'(rank);
      count = 64'(cfg_total);
      items = n;
      picks = k;
      pos = 0;
      bad = (n == 0 || n > MAX_SET || k == 0 || k > n || k > MAX_PICK ||
             left == 0 || left > count);
      while (!bad && picks > 1) begin
         if (items < picks) begin
            // A wrong total ran the walk out of candidates.
            bad = 1'b1;
         end else begin
            share = (count * picks) / items;
            if (left <= share) begin
               chosen[pos] = SET_W'(n - items + 1);
               pos++;
               count = share;
               picks--;
            end else begin
               left -= share;
               count -= share;
            end
            items--;
         end
      end
      if (!bad) begin
         final_el = (n - items) + left;
         bad = (final_el < 1 || final_el > n);
         chosen[pos] = SET_W'(final_el);
         pos++;
      end
      if (bad) begin
         beat.element = '0;
         beat.last = 1'b1;
         beat.error = 1'b1;
         expected_beats.push_back(beat);
         error_ranks++;
      end else begin
         for (int r = 0; r < pos; r++) begin
            beat.element = chosen[r];
            beat.last = (r == pos - 1);
            beat.error = 1'b0;
            expected_beats.push_back(beat);
         end
      end
   endfunction

   // Every result beat is compared against the oldest expected beat.
   always @(posedge clock) begin
      element_beat_type got;
      element_beat_type want;
      if (!reset && rsp_strobe) begin
         got.element = rsp_element;
         got.last = rsp_last;
         got.error = rsp_error;
         beats_checked++;
         if (expected_beats.size() == 0) begin
            note_mismatch($sformatf("unexpected beat: element %0d last %0b error %0b",
                                    got.element, got.last, got.error));
         end else begin
            want = expected_beats.pop_front();
            if (got.element !== want.element || got.last !== want.last ||
                got.error !== want.error)
               note_mismatch($sformatf(
                  "expected element %0d last %0b error %0b, got %0d %0b %0b",
                  want.element, want.last, want.error,
                  got.element, got.last, got.error));
         end
      end
   end

   // Offer one rank and hold it, dropping start now and then, until taken.
   task automatic send_rank(input logic [COUNT_W-1:0] rank);
      bit offered;
      if (idle_enable && $urandom_range(0, 99) < 24) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_rank <= rank;
      forever begin
         @(posedge clock);
         if (start && !busy)
            break;
         offered = !(idle_enable && $urandom_range(0, 99) < 24);
         start <= offered;
         req_rank <= offered ? rank : COUNT_W'({$urandom, $urandom});
      end
      predict_subset(rank);
      ranks_sent++;
   endtask

   // Hold off the sender until every expected beat is in and busy is low.
   task automatic wait_for_results();
      start <= 1'b0;
      do
         @(posedge clock);
      while (expected_beats.size() != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   // One write followed back to back by a read of the same register.
   task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [63:0] value);
      logic [DATA_W-1:0] stored;
      stored = '0;
      case (addr)
         REG_SET_SIZE: begin
            cfg_set_size = value[SET_W-1:0];
            stored = DATA_W'(cfg_set_size);
         end
         REG_SUBSET_SIZE: begin
            cfg_subset_size = value[PICK_W-1:0];
            stored = DATA_W'(cfg_subset_size);
         end
         REG_TOTAL_COUNT: begin
            cfg_total = value[COUNT_W-1:0];
            stored = DATA_W'(cfg_total);
         end
         default: ;
      endcase
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== stored)
         note_mismatch($sformatf("register at %0d reads %0h, expected %0h",
                                 addr, prdata, stored));
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int n, input int k, input logic [63:0] total);
      wait_for_results();
      write_register(REG_SET_SIZE, 64'(n));
      write_register(REG_SUBSET_SIZE, 64'(k));
      write_register(REG_TOTAL_COUNT, total);
      settings_used++;
   endtask

   // Mostly ranks inside 1..total, with the ends and some out-of-range noise.
   function automatic logic [COUNT_W-1:0] pick_rank(input logic [63:0] total);
      int          roll;
      logic [63:0] wide;
      roll = $urandom_range(0, 99);
      wide = {$urandom, $urandom};
      if (roll < 5)
         return 1;
      if (roll < 10)
         return COUNT_W'(total);
      if (roll < 14)
         return 0;
      if (roll < 18)
         return COUNT_W'(total + 64'd1);
      if (roll < 22)
         return COUNT_W'(wide);
      return COUNT_W'((wide % total) + 64'd1);
   endfunction

   // The reset settings: n = k = total = 1.
   task automatic test_reset_settings();
      send_rank(1);
      send_rank(0);
      send_rank(2);
      send_rank(COUNT_W'(COUNT_MASK));
   endtask

   task automatic test_small_walks();
      configure(5, 3, 10);
      send_rank(1);
      send_rank(10);
      send_rank(4);
      send_rank(11);
      // A full set gives the sixteen-element identity combination.
      configure(16, 16, 1);
      send_rank(1);
      configure(64, 1, 64);
      send_rank(64);
      send_rank(1);
   endtask

   task automatic test_largest_set();
      logic [63:0] total;
      total = choose(MAX_SET, MAX_PICK);
      configure(MAX_SET, MAX_PICK, total);
      send_rank(1);
      send_rank(COUNT_W'(total));
      send_rank(COUNT_W'(total + 64'd1));
   endtask

   // Settings that the block must refuse outright.
   task automatic test_bad_settings();
      configure(0, 1, 1);
      send_rank(1);
      configure(127, 31, COUNT_MASK);
      send_rank(5);
      configure(64, 17, 1);
      send_rank(1);
      configure(3, 4, 1);
      send_rank(1);
      configure(20, 0, 1);
      send_rank(1);
   endtask

   // Totals that do not match n and k can send the walk astray.
   task automatic test_wrong_totals();
      configure(5, 3, 1000);
      send_rank(500);
      send_rank(10);
      configure(8, 4, COUNT_MASK);
      send_rank(COUNT_W'(COUNT_MASK));
   endtask

   task automatic test_consistent_walks();
      int          n;
      int          k;
      int          items;
      logic [63:0] total;
      for (int phase = 0; phase < 12; phase++) begin
         // Large sets are slow, so only two phases use them.
         if (phase % 6 == 3) begin
            n = $urandom_range(40, MAX_SET);
            items = 6;
         end else begin
            n = $urandom_range(1, 20);
            items = 20;
         end
         k = $urandom_range(1, n < MAX_PICK ? n : MAX_PICK);
         total = choose(n, k);
         idle_enable = (phase != 5);
         configure(n, k, total);
         for (int t = 0; t < items; t++) begin
            if ($urandom_range(0, 39) == 0)
               wait_for_results();
            send_rank(pick_rank(total));
         end
      end
      idle_enable = 1'b1;
   endtask

   task automatic test_broken_settings();
      int          n;
      int          k;
      logic [63:0] total;
      logic [63:0] wide;
      for (int phase = 0; phase < 5; phase++) begin
         wide = {$urandom, $urandom};
         case (phase)
            0: begin
               n = $urandom_range(1, 15);
               k = $urandom_range(n + 1, 31);
               total = 64'($urandom_range(1, 1000));
            end
            1: begin
               n = $urandom_range(MAX_SET + 1, 127);
               k = $urandom_range(1, MAX_PICK);
               total = 64'($urandom_range(1, 1000000));
            end
            2: begin
               n = $urandom_range(MAX_PICK + 1, MAX_SET);
               k = $urandom_range(MAX_PICK + 1, n < 31 ? n : 31);
               total = 64'($urandom_range(1, 1000000));
            end
            3: begin
               n = $urandom_range(4, 30);
               k = $urandom_range(2, n < MAX_PICK ? n : MAX_PICK);
               total = choose(n, k) * 3;
            end
            default: begin
               n = $urandom_range(4, 30);
               k = $urandom_range(2, n < MAX_PICK ? n : MAX_PICK);
               total = (wide & COUNT_MASK) | 64'd1;
            end
         endcase
         configure(n, k, total);
         for (int t = 0; t < 10; t++)
            send_rank(pick_rank(total));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_settings();
      test_small_walks();
      test_largest_set();
      test_bad_settings();
      test_wrong_totals();
      test_consistent_walks();
      test_broken_settings();
      wait_for_results();
      $display("Sent %0d ranks under %0d register settings; %0d expected an error beat.",
               ranks_sent, settings_used, error_ranks);
      $display("Checked %0d result beats, %0d mismatches.", beats_checked, mismatch_count);
      if (mismatch_count == 0 && expected_beats.size() == 0)
         $display("combination_unrank_lex_test passed");
      else
         $display("combination_unrank_lex_test failed");
      $finish;
   end

endmodule
